>>> hw/rtl/wsd_pkg.sv
// shared constants, types and helpers of the work stealing deque unit
`default_nettype none

package wsd_pkg;

   // capacity of the handle store
   localparam int DEPTH = 1024;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int HANDLE_W = 64;
   localparam int CMD_W = 2;
   localparam int STAT_W = 2;

   // response word: handle in the low bits, occupancy above, zero pad to whole bytes
   localparam int RSP_DATA_W = ((HANDLE_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_DATA_W - HANDLE_W - CNT_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_STEAL = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } stat_type;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/work_stealing_deque_unit.sv
// top level of the work stealing deque unit: handle store, index logic and response stage
//
// one request word per command, one response word back for each, in order.
// req_tuser carries the command (push at the owner end, pop at the owner end,
// steal at the far end, clear), req_tdata the task handle that push stores.
// rsp_tdata returns the removed handle (zero unless a pop or steal succeeded)
// with the occupancy after the command, rsp_tuser the status (ok, empty, full).
// the store is one synchronous memory whose read data is registered. the
// near and far indices and the held count update in the cycle a request is
// taken, while that cycle's memory access is issued; the read data is held
// in the read stage and from there enters the response register.
// throughput: one command per cycle while responses are taken; the single
// store port (one write or one read per command) sets that figure.
// a push lands in memory at the edge where it is taken, so a pop in the next
// cycle already reads it.
// reset clears the indices, the count and both valid flags and holds
// req_tready low; the store itself is not cleared, since no unwritten entry
// is ever returned in a response.
// when the receiver stalls, the response register holds, the read stage
// behind it fills, and then req_tready drops until the response is taken.
`default_nettype none

module work_stealing_deque_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [wsd_pkg::HANDLE_W-1:0]     req_tdata,   // [63:0] task_handle
   input  wire logic [wsd_pkg::CMD_W-1:0]        req_tuser,   // [1:0] command
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [wsd_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [63:0] popped_handle,
                                                              // [74:64] occupancy, zero pad
   output logic [wsd_pkg::STAT_W-1:0]            rsp_tuser    // [1:0] status
);

   // index and count state
   logic [wsd_pkg::IDX_W-1:0]    near_ff, near_in;
   logic [wsd_pkg::IDX_W-1:0]    far_ff, far_in;
   logic [wsd_pkg::CNT_W-1:0]    count_ff, count_in;

   // handle store
   logic [wsd_pkg::HANDLE_W-1:0] handle_store [wsd_pkg::DEPTH];
   logic [wsd_pkg::HANDLE_W-1:0] rd_data_ff;

   // read stage: command issued, memory data arriving
   logic                         p_valid_ff;
   logic                         p_take_ff;
   wsd_pkg::stat_type            p_status_ff;
   logic [wsd_pkg::CNT_W-1:0]    p_occ_ff;

   // response register
   logic                         o_valid_ff;
   logic [wsd_pkg::RSP_DATA_W-1:0] o_data_ff, o_data_in;
   wsd_pkg::stat_type            o_status_ff;

   // per-command decode
   wsd_pkg::cmd_type             cmd;
   wsd_pkg::stat_type            status;
   logic [wsd_pkg::IDX_W-1:0]    acc_addr;
   logic                         wr_en;
   logic                         take;
   logic                         acc;
   logic                         o_load;

   assign cmd = wsd_pkg::cmd_type'(req_tuser);

   // read stage moves on when the response register is free or being emptied
   assign o_load     = p_valid_ff && (!o_valid_ff || rsp_tready);
   assign req_tready = !reset && (!p_valid_ff || o_load);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      near_in  = near_ff;
      far_in   = far_ff;
      count_in = count_ff;
      status   = wsd_pkg::ST_OK;
      acc_addr = far_ff;
      wr_en    = 1'b0;
      take     = 1'b0;
      unique case (cmd)
         wsd_pkg::CMD_PUSH: begin
            acc_addr = near_ff;
            if (count_ff == wsd_pkg::FULL_CNT) begin
               status = wsd_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               near_in  = wsd_pkg::wrap_inc(near_ff);
               count_in = count_ff + 1'b1;
            end
         end
         wsd_pkg::CMD_POP: begin
            // newest handle sits just below the near index
            acc_addr = wsd_pkg::wrap_dec(near_ff);
            if (count_ff == '0) begin
               status = wsd_pkg::ST_EMPTY;
            end else begin
               take     = 1'b1;
               near_in  = acc_addr;
               count_in = count_ff - 1'b1;
            end
         end
         wsd_pkg::CMD_STEAL: begin
            // oldest handle sits at the far index
            acc_addr = far_ff;
            if (count_ff == '0) begin
               status = wsd_pkg::ST_EMPTY;
            end else begin
               take     = 1'b1;
               far_in   = wsd_pkg::wrap_inc(far_ff);
               count_in = count_ff - 1'b1;
            end
         end
         wsd_pkg::CMD_CLEAR: begin
            far_in   = near_ff;
            count_in = '0;
         end
         default: begin
            status = wsd_pkg::ST_OK;
         end
      endcase
   end

   // index state commits only when a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff  <= '0;
         far_ff   <= '0;
         count_ff <= '0;
      end else if (acc) begin
         near_ff  <= near_in;
         far_ff   <= far_in;
         count_ff <= count_in;
      end
   end

   // single port store: push writes, everything else reads
   always_ff @(posedge clock) begin
      if (acc && wr_en) begin
         handle_store[acc_addr] <= req_tdata;
      end
   end

   // read data holds while the read stage waits on a stalled response
   always_ff @(posedge clock) begin
      if (acc && !wr_en) begin
         rd_data_ff <= handle_store[acc_addr];
      end
   end

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (acc) begin
         p_valid_ff <= 1'b1;
      end else if (o_load) begin
         p_valid_ff <= 1'b0;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (acc) begin
         p_take_ff   <= take;
         p_status_ff <= status;
         p_occ_ff    <= count_in;
      end
   end

   // handle is zeroed unless a pop or steal removed one
   always_comb begin
      o_data_in = {{wsd_pkg::RSP_PAD_W{1'b0}}, p_occ_ff,
                   p_take_ff ? rd_data_ff : {wsd_pkg::HANDLE_W{1'b0}}};
   end

   // response register control
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_load) begin
         o_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         o_valid_ff <= 1'b0;
      end
   end

   // response register payload
   always_ff @(posedge clock) begin
      if (o_load) begin
         o_data_ff   <= o_data_in;
         o_status_ff <= p_status_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tuser  = o_status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/wsd_checker.sv
// port-level checker of the work stealing deque unit and its bind
`default_nettype none

module wsd_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [wsd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic [wsd_pkg::STAT_W-1:0]       rsp_tuser
);

   logic [wsd_pkg::HANDLE_W-1:0] handle;
   logic [wsd_pkg::CNT_W-1:0]    occ;

   assign handle = rsp_tdata[wsd_pkg::HANDLE_W-1:0];
   assign occ    = rsp_tdata[wsd_pkg::HANDLE_W +: wsd_pkg::CNT_W];

   // a refused or empty command never returns a handle
   a_no_handle_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == wsd_pkg::ST_EMPTY || rsp_tuser == wsd_pkg::ST_FULL)
      |-> handle == '0)
      else $error("handle returned with a failing status");

   // full is only reported at capacity, empty only with nothing held
   a_status_matches_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid
      |-> (rsp_tuser != wsd_pkg::ST_FULL || occ == wsd_pkg::FULL_CNT)
       && (rsp_tuser != wsd_pkg::ST_EMPTY || occ == '0))
      else $error("status disagrees with occupancy");

   // occupancy never exceeds capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ <= wsd_pkg::FULL_CNT)
      else $error("occupancy above capacity");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

endmodule

bind work_stealing_deque_unit wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench of the work stealing deque unit
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wsd_pkg::*;

   // one expected response word: handle removed, status, occupancy afterwards
   typedef struct {
      logic [HANDLE_W-1:0] handle;
      stat_type            status;
      logic [CNT_W-1:0]    occupancy;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, driven at the rising edge
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [HANDLE_W-1:0]   req_tdata  = '0;   // [63:0] task_handle
   logic [CMD_W-1:0]      req_tuser  = CMD_PUSH;   // [1:0] command

   // response channel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [63:0] popped_handle, [74:64] occupancy, zero pad
   logic [STAT_W-1:0]     rsp_tuser;   // [1:0] status

   work_stealing_deque_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // shadow copy of the deque: store, both ends and the held count
   logic [HANDLE_W-1:0] shadow_handles [DEPTH];
   logic [IDX_W-1:0]    far_slot = '0;
   logic [IDX_W-1:0]    near_slot = '0;
   int                  held = 0;

   // responses still owed by the block, oldest first
   deque_result_type    results_due[$];

   // traffic shaping shared by sender and receiver
   bit no_idle = 1'b0;      // both sides run flat out
   int hold_request = 0;    // asks the receiver for one long hold-off
   int hold_left = 0;
   int stall_left = 0;

   // run statistics
   int errors = 0;
   int words_checked = 0;
   int n_push = 0, n_full = 0, n_pop = 0, n_steal = 0, n_empty = 0, n_clear = 0;
   int peak_held = 0;

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // apply one accepted command to the shadow deque and queue the response it owes
   task automatic deque_step(input cmd_type cmd, input logic [HANDLE_W-1:0] handle);
      deque_result_type res;
      res.handle = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            n_push++;
            if (held >= DEPTH) begin
               // no room: refused, nothing changes
               res.status = ST_FULL;
               n_full++;
            end else begin
               shadow_handles[near_slot] = handle;
               near_slot = (near_slot == IDX_W'(DEPTH - 1)) ? '0 : near_slot + 1'b1;
               held++;
            end
         end
         CMD_POP: begin
            n_pop++;
            if (held == 0) begin
               res.status = ST_EMPTY;
               n_empty++;
            end else begin
               // owner end: newest handle first
               near_slot = (near_slot == '0) ? IDX_W'(DEPTH - 1) : near_slot - 1'b1;
               res.handle = shadow_handles[near_slot];
               held--;
            end
         end
         CMD_STEAL: begin
            n_steal++;
            if (held == 0) begin
               res.status = ST_EMPTY;
               n_empty++;
            end else begin
               // far end: oldest handle first
               res.handle = shadow_handles[far_slot];
               far_slot = (far_slot == IDX_W'(DEPTH - 1)) ? '0 : far_slot + 1'b1;
               held--;
            end
         end
         default: begin
            // clear drops everything, store contents stay as they are
            n_clear++;
            far_slot = near_slot;
            held = 0;
         end
      endcase
      res.occupancy = CNT_W'(held);
      if (held > peak_held) peak_held = held;
      results_due.push_back(res);
   endtask

   // offer one request word after a random gap, then wait for the handshake
   task automatic send_word(input cmd_type cmd, input logic [HANDLE_W-1:0] handle);
      int gap;
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 20);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= handle;
      do @(posedge clock); while (!req_tready);
      deque_step(cmd, handle);
   endtask

   // stop offering and wait until every owed response has come back
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   function automatic logic [HANDLE_W-1:0] random_handle;
      int r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 6) return '1;
      return {$urandom, $urandom};
   endfunction

   // pop or steal, picked at random
   function automatic cmd_type random_removal;
      return ($urandom_range(1) != 0) ? CMD_POP : CMD_STEAL;
   endfunction

   // receiver: random stalls, an occasional long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         int r;
         r = $urandom_range(99);
         if (r < 75) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
         end
      end
   end

   // response checker: every accepted word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         deque_result_type want;
         if (results_due.size() == 0) begin
            $display("%0t: response word with nothing expected: handle %h status %0d occ %0d",
                     $realtime, rsp_tdata[HANDLE_W-1:0], rsp_tuser,
                     rsp_tdata[HANDLE_W +: CNT_W]);
            errors++;
         end else begin
            want = results_due.pop_front();
            words_checked++;
            if (rsp_tdata[HANDLE_W-1:0] !== want.handle) begin
               $display("%0t: handle mismatch, expected %h, actual %h",
                        $realtime, want.handle, rsp_tdata[HANDLE_W-1:0]);
               errors++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $realtime, want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[HANDLE_W +: CNT_W] !== want.occupancy) begin
               $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                        $realtime, want.occupancy, rsp_tdata[HANDLE_W +: CNT_W]);
               errors++;
            end
         end
      end
   end

   // empty store, single handle at either end, lifo and fifo order, clear
   task automatic test_directed;
      send_word(CMD_POP, 64'h5555_5555_5555_5555);     // pop of empty store
      send_word(CMD_STEAL, 64'hAAAA_AAAA_AAAA_AAAA);   // steal of empty store
      send_word(CMD_CLEAR, '1);                        // clear of empty store
      send_word(CMD_PUSH, '0);
      send_word(CMD_POP, '1);                          // single handle taken by pop
      send_word(CMD_PUSH, '1);
      send_word(CMD_STEAL, '0);                        // single handle taken by steal
      send_word(CMD_PUSH, 64'h5555_5555_5555_5555);
      send_word(CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(CMD_PUSH, 64'h0123_4567_89AB_CDEF);
      send_word(CMD_POP, '0);                          // newest
      send_word(CMD_STEAL, '0);                        // oldest
      send_word(CMD_POP, '0);
      send_word(CMD_POP, '0);                          // empty again
      send_word(CMD_PUSH, 64'hFEDC_BA98_7654_3210);
      send_word(CMD_PUSH, 64'h8000_0000_0000_0001);
      send_word(CMD_CLEAR, '0);                        // clear with handles held
      send_word(CMD_POP, '0);
      send_word(CMD_STEAL, '0);
      send_word(CMD_PUSH, 64'h7FFF_FFFF_FFFF_FFFE);
      send_word(CMD_STEAL, '0);
      wait_drained();
   endtask

   // fill to capacity behind a long receiver hold-off, refuse pushes, wrap, clear
   task automatic test_fill_and_drain;
      int need;
      need = DEPTH - held;
      hold_request = 150;   // block backs up and stalls its request side
      for (int i = 0; i < need; i++) send_word(CMD_PUSH, random_handle());
      send_word(CMD_PUSH, '0);                         // full store refuses
      send_word(CMD_PUSH, '1);
      send_word(CMD_STEAL, '0);
      send_word(CMD_PUSH, 64'hC3C3_C3C3_C3C3_C3C3);
      send_word(CMD_PUSH, 64'h3C3C_3C3C_3C3C_3C3C);    // full again
      send_word(CMD_POP, '0);
      send_word(CMD_PUSH, 64'h0F0F_0F0F_F0F0_F0F0);
      wait_drained();
      // random pops and steals: the owner end walks back, the far end walks forward
      for (int i = 0; i < 24; i++) send_word(random_removal(), random_handle());
      send_word(CMD_CLEAR, '0);                        // clear a nearly full store
      send_word(CMD_POP, '0);
      wait_drained();
   endtask

   // random traffic in phases, each steering the occupancy toward its own level
   task automatic test_random_traffic;
      int level;
      int r;
      int push_pct;
      for (int phase = 0; phase < 13; phase++) begin
         no_idle = (phase % 4 == 3);
         case (phase % 3)
            0: level = $urandom_range(0, 4);
            1: level = $urandom_range(10, 60);
            default: level = $urandom_range(100, 300);
         endcase
         for (int i = 0; i < 20; i++) begin
            push_pct = (held < level) ? 70 : 30;
            r = $urandom_range(99);
            if (r < 3) send_word(CMD_CLEAR, random_handle());
            else if (r < 3 + push_pct) send_word(CMD_PUSH, random_handle());
            else send_word(random_removal(), random_handle());
         end
         // one sender pause in the middle of the run
         if (phase == 6) wait_drained();
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_random_traffic();
      // let any stray word show up before the verdict
      repeat (10) @(posedge clock);
      $display("run covered %0d pushes (%0d refused full), %0d pops, %0d steals, %0d clears",
               n_push, n_full, n_pop, n_steal, n_clear);
      $display("%0d empty removals, peak occupancy %0d, %0d response words checked",
               n_empty, peak_held, words_checked);
      if (errors == 0 && results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/wsd_pkg.sv
hw/rtl/work_stealing_deque_unit.sv
hw/rtl/wsd_checker.sv
tb/tb_top.sv
